[rtl/mas_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mas_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int ROW_AW    = MEM_AW - 1;
    localparam int ROWS      = MEM_BYTES / 2;
    localparam int NREGS     = 14;
    localparam int PA_W      = 20;
    localparam int DF_BIT    = 10;

    localparam logic [3:0] MODE_IMM16 = 4'd0;
    localparam logic [3:0] MODE_IMM8  = 4'd1;
    localparam logic [3:0] MODE_REG16 = 4'd2;
    localparam logic [3:0] MODE_REG8  = 4'd3;
    localparam logic [3:0] MODE_LOAD  = 4'd4;
    localparam logic [3:0] MODE_STORE = 4'd5;
    localparam logic [3:0] MODE_STOSB = 4'd6;
    localparam logic [3:0] MODE_STOSW = 4'd7;
    localparam logic [3:0] MODE_LODSB = 4'd8;
    localparam logic [3:0] MODE_LODSW = 4'd9;
    localparam logic [3:0] MODE_MOVSB = 4'd10;
    localparam logic [3:0] MODE_MOVSW = 4'd11;

    localparam logic [3:0] REG_AX         = 4'd0;
    localparam logic [3:0] REG_SI         = 4'd6;
    localparam logic [3:0] REG_DI         = 4'd7;
    localparam logic [3:0] REG_ES         = 4'd8;
    localparam logic [3:0] REG_DS         = 4'd11;
    localparam logic [3:0] REG_FLAGS      = 4'd13;
    localparam logic [3:0] REG_COUNT      = 4'd14;
    localparam logic [3:0] BYTE_REG_COUNT = 4'd8;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_IMM16,
        OP_IMM8,
        OP_REG16,
        OP_REG8,
        OP_LOAD8,
        OP_LOAD16,
        OP_STORE8,
        OP_STORE16,
        OP_STOS,
        OP_LODS,
        OP_MOVS
    } t_op_kind;

    typedef struct packed {
        t_op_kind         kind;
        logic             word;
        logic [3:0]       dst;
        logic             dst_hi;
        logic [3:0]       src;
        logic             src_hi;
        logic [15:0]      imm;
        logic [PA_W-1:0]  addr;
    } t_op;

    typedef struct packed {
        logic [15:0]      dest_value;
        logic             mem_written;
        logic [PA_W-1:0]  write_addr;
        logic [15:0]      write_data;
        logic             write_is_word;
        logic [15:0]      si_now;
        logic [15:0]      di_now;
    } t_result;

    typedef enum logic [1:0] {
        EX_CLEAR,
        EX_IDLE,
        EX_ADDR,
        EX_DATA
    } t_ex_state;

    function automatic logic [15:0] merge8(input logic [15:0] old, input logic [7:0] b,
                                           input logic hi);
        return hi ? {b, old[7:0]} : {old[15:8], b};
    endfunction

    function automatic logic [PA_W-1:0] phys(input logic [15:0] seg, input logic [15:0] off);
        return {seg, 4'h0} + {4'h0, off};
    endfunction

    function automatic logic [15:0] step_idx(input logic [15:0] v, input logic word,
                                             input logic df);
        logic [15:0] amount;
        amount = word ? 16'd2 : 16'd1;
        return df ? (v - amount) : (v + amount);
    endfunction

endpackage

`default_nettype wire

[rtl/mas_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module mas_front
    import mas_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_hold,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [3:0]        i_mode,
    input  wire logic [3:0]        i_dst_reg,
    input  wire logic [3:0]        i_src_reg,
    input  wire logic              i_byte_access,
    input  wire logic [15:0]       i_imm_value,
    input  wire logic [PA_W-1:0]   i_mem_addr,
    output logic                   o_op_valid,
    output t_op                    o_op,
    input  wire logic              i_op_pop
);

    t_op        n_op;
    t_op        r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_level;
    logic       push_ok;

    always_comb begin
        n_op        = '0;
        n_op.kind   = OP_NOP;
        n_op.imm    = i_imm_value;
        n_op.addr   = i_mem_addr;
        unique case (i_mode) inside
            MODE_IMM16: begin
                if (i_dst_reg < REG_COUNT) begin
                    n_op.kind = OP_IMM16;
                    n_op.dst  = i_dst_reg;
                end
            end
            MODE_IMM8: begin
                if (i_dst_reg < BYTE_REG_COUNT) begin
                    n_op.kind   = OP_IMM8;
                    n_op.dst    = {2'b00, i_dst_reg[1:0]};
                    n_op.dst_hi = i_dst_reg[2];
                end
            end
            MODE_REG16: begin
                if (i_dst_reg < REG_COUNT && i_src_reg < REG_COUNT) begin
                    n_op.kind = OP_REG16;
                    n_op.dst  = i_dst_reg;
                    n_op.src  = i_src_reg;
                end
            end
            MODE_REG8: begin
                if (i_dst_reg < BYTE_REG_COUNT && i_src_reg < BYTE_REG_COUNT) begin
                    n_op.kind   = OP_REG8;
                    n_op.dst    = {2'b00, i_dst_reg[1:0]};
                    n_op.dst_hi = i_dst_reg[2];
                    n_op.src    = {2'b00, i_src_reg[1:0]};
                    n_op.src_hi = i_src_reg[2];
                end
            end
            MODE_LOAD: begin
                if (i_byte_access) begin
                    if (i_dst_reg < BYTE_REG_COUNT) begin
                        n_op.kind   = OP_LOAD8;
                        n_op.dst    = {2'b00, i_dst_reg[1:0]};
                        n_op.dst_hi = i_dst_reg[2];
                    end
                end else if (i_dst_reg < REG_COUNT) begin
                    n_op.kind = OP_LOAD16;
                    n_op.dst  = i_dst_reg;
                end
            end
            MODE_STORE: begin
                if (i_byte_access) begin
                    if (i_src_reg < BYTE_REG_COUNT) begin
                        n_op.kind   = OP_STORE8;
                        n_op.src    = {2'b00, i_src_reg[1:0]};
                        n_op.src_hi = i_src_reg[2];
                    end
                end else if (i_src_reg < REG_COUNT) begin
                    n_op.kind = OP_STORE16;
                    n_op.src  = i_src_reg;
                end
            end
            MODE_STOSB, MODE_STOSW: begin
                n_op.kind = OP_STOS;
                n_op.word = (i_mode == MODE_STOSW);
            end
            MODE_LODSB, MODE_LODSW: begin
                n_op.kind = OP_LODS;
                n_op.word = (i_mode == MODE_LODSW);
                n_op.dst  = REG_AX;
            end
            MODE_MOVSB, MODE_MOVSW: begin
                n_op.kind = OP_MOVS;
                n_op.word = (i_mode == MODE_MOVSW);
            end
            default: begin
                n_op.kind = OP_NOP;
            end
        endcase
    end

    assign o_full     = (r_level == 2'd2) || i_hold;
    assign push_ok    = i_push && !o_full;
    assign o_op_valid = (r_level != 2'd0);
    assign o_op       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_op_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push_ok, i_op_pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/mas_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module mas_back
    import mas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_op_valid,
    input  wire t_op         i_op,
    output logic             o_op_pop,
    input  wire logic [1:0]  i_rq_level,
    output logic             o_res_push,
    output t_result          o_res,
    output logic             o_clearing
);

    t_ex_state          r_state;
    t_ex_state          n_state;
    t_op                r_op;
    logic [15:0]        r_regs [NREGS];
    logic [15:0]        r_src_val;
    logic               r_rd_swap;
    logic [PA_W-1:0]    r_wr_addr;
    logic [7:0]         r_mem_even [ROWS];
    logic [7:0]         r_mem_odd  [ROWS];
    logic [7:0]         r_even_q;
    logic [7:0]         r_odd_q;
    logic [ROW_AW-1:0]  r_clr_row;

    logic               room;
    logic               start;
    logic               exec;
    logic               clr_en;

    logic [3:0]         rd_idx;
    logic [15:0]        rd_val;
    logic [PA_W-1:0]    src_pa;
    logic [PA_W-1:0]    dst_pa;
    logic [MEM_AW-1:0]  rd_m;
    logic [ROW_AW-1:0]  rd_row;
    logic [ROW_AW-1:0]  ev_rd_row;

    logic [7:0]         lo;
    logic [7:0]         hi;
    logic [15:0]        mem_word;
    logic [7:0]         src_byte;
    logic               df;
    logic               wr_en;
    logic [15:0]        wr_val;
    logic               mw;
    logic               wword;
    logic [15:0]        wdata;
    logic               step_si;
    logic               step_di;
    logic [15:0]        n_si;
    logic [15:0]        n_di;

    logic [MEM_AW-1:0]  wr_m;
    logic [ROW_AW-1:0]  wr_row;
    logic               ev_we;
    logic               od_we;
    logic [ROW_AW-1:0]  ev_wr_row;
    logic [ROW_AW-1:0]  od_wr_row;
    logic [7:0]         ev_wr_data;
    logic [7:0]         od_wr_data;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            EX_CLEAR: begin
                if (r_clr_row == {ROW_AW{1'b1}}) begin
                    n_state = EX_IDLE;
                end
            end
            EX_IDLE: begin
                if (start) begin
                    n_state = EX_ADDR;
                end
            end
            EX_ADDR: begin
                n_state = EX_DATA;
            end
            EX_DATA: begin
                n_state = start ? EX_ADDR : EX_IDLE;
            end
            default: begin
                n_state = EX_IDLE;
            end
        endcase
    end

    always_comb begin
        room       = ({1'b0, i_rq_level} + {2'b00, (r_state == EX_DATA)}) < 3'd2;
        start      = i_op_valid && room && (r_state == EX_IDLE || r_state == EX_DATA);
        exec       = (r_state == EX_DATA);
        clr_en     = (r_state == EX_CLEAR);
        o_op_pop   = start;
        o_res_push = exec;
        o_clearing = clr_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= EX_CLEAR;
            r_clr_row <= '0;
        end else begin
            r_state <= n_state;
            if (clr_en) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
        end
    end

    // address phase
    always_comb begin
        rd_idx    = (r_state == EX_ADDR) ? r_op.src : r_op.dst;
        rd_val    = r_regs[rd_idx];
        src_pa    = (r_op.kind == OP_LOAD8 || r_op.kind == OP_LOAD16)
                  ? r_op.addr : phys(r_regs[REG_DS], r_regs[REG_SI]);
        dst_pa    = (r_op.kind == OP_STORE8 || r_op.kind == OP_STORE16)
                  ? r_op.addr : phys(r_regs[REG_ES], r_regs[REG_DI]);
        rd_m      = src_pa[MEM_AW-1:0];
        rd_row    = rd_m[MEM_AW-1:1];
        ev_rd_row = rd_m[0] ? (rd_row + 1'b1) : rd_row;
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op <= i_op;
        end
        if (r_state == EX_ADDR) begin
            r_src_val <= rd_val;
            r_rd_swap <= rd_m[0];
            r_wr_addr <= dst_pa;
        end
    end

    // data phase
    always_comb begin
        lo       = r_rd_swap ? r_odd_q : r_even_q;
        hi       = r_rd_swap ? r_even_q : r_odd_q;
        mem_word = {hi, lo};
        src_byte = r_op.src_hi ? r_src_val[15:8] : r_src_val[7:0];
        df       = r_regs[REG_FLAGS][DF_BIT];
        wr_en    = 1'b0;
        wr_val   = 16'h0000;
        mw       = 1'b0;
        wword    = 1'b0;
        wdata    = 16'h0000;
        step_si  = 1'b0;
        step_di  = 1'b0;
        case (r_op.kind)
            OP_IMM16: begin
                wr_en  = 1'b1;
                wr_val = r_op.imm;
            end
            OP_IMM8: begin
                wr_en  = 1'b1;
                wr_val = merge8(rd_val, r_op.imm[7:0], r_op.dst_hi);
            end
            OP_REG16: begin
                wr_en  = 1'b1;
                wr_val = r_src_val;
            end
            OP_REG8: begin
                wr_en  = 1'b1;
                wr_val = merge8(rd_val, src_byte, r_op.dst_hi);
            end
            OP_LOAD8: begin
                wr_en  = 1'b1;
                wr_val = merge8(rd_val, lo, r_op.dst_hi);
            end
            OP_LOAD16: begin
                wr_en  = 1'b1;
                wr_val = mem_word;
            end
            OP_STORE8: begin
                mw    = 1'b1;
                wdata = {8'h00, src_byte};
            end
            OP_STORE16: begin
                mw    = 1'b1;
                wword = 1'b1;
                wdata = r_src_val;
            end
            OP_STOS: begin
                mw      = 1'b1;
                wword   = r_op.word;
                wdata   = r_op.word ? r_regs[REG_AX] : {8'h00, r_regs[REG_AX][7:0]};
                step_di = 1'b1;
            end
            OP_LODS: begin
                wr_en   = 1'b1;
                wr_val  = r_op.word ? mem_word : merge8(rd_val, lo, 1'b0);
                step_si = 1'b1;
            end
            OP_MOVS: begin
                mw      = 1'b1;
                wword   = r_op.word;
                wdata   = r_op.word ? mem_word : {8'h00, lo};
                step_si = 1'b1;
                step_di = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase

        if (step_si) begin
            n_si = step_idx(r_regs[REG_SI], r_op.word, df);
        end else if (wr_en && r_op.dst == REG_SI) begin
            n_si = wr_val;
        end else begin
            n_si = r_regs[REG_SI];
        end
        if (step_di) begin
            n_di = step_idx(r_regs[REG_DI], r_op.word, df);
        end else if (wr_en && r_op.dst == REG_DI) begin
            n_di = wr_val;
        end else begin
            n_di = r_regs[REG_DI];
        end

        o_res.dest_value    = wr_en ? wr_val : 16'h0000;
        o_res.mem_written   = mw;
        o_res.write_addr    = mw ? r_wr_addr : '0;
        o_res.write_data    = wdata;
        o_res.write_is_word = wword;
        o_res.si_now        = n_si;
        o_res.di_now        = n_di;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NREGS; k++) begin
                r_regs[k] <= 16'h0000;
            end
        end else if (exec) begin
            for (int k = 0; k < NREGS; k++) begin
                if (4'(k) == REG_SI) begin
                    r_regs[k] <= n_si;
                end else if (4'(k) == REG_DI) begin
                    r_regs[k] <= n_di;
                end else if (wr_en && r_op.dst == 4'(k)) begin
                    r_regs[k] <= wr_val;
                end
            end
        end
    end

    // byte banks: even and odd addresses, so any word touches each bank once
    always_comb begin
        wr_m       = r_wr_addr[MEM_AW-1:0];
        wr_row     = wr_m[MEM_AW-1:1];
        ev_we      = 1'b0;
        od_we      = 1'b0;
        ev_wr_row  = wr_row;
        od_wr_row  = wr_row;
        ev_wr_data = wdata[7:0];
        od_wr_data = wdata[7:0];
        if (clr_en) begin
            ev_we      = 1'b1;
            od_we      = 1'b1;
            ev_wr_row  = r_clr_row;
            od_wr_row  = r_clr_row;
            ev_wr_data = 8'h00;
            od_wr_data = 8'h00;
        end else if (exec && mw) begin
            if (!wr_m[0]) begin
                ev_we      = 1'b1;
                od_we      = wword;
                od_wr_data = wdata[15:8];
            end else begin
                od_we      = 1'b1;
                ev_we      = wword;
                ev_wr_row  = wr_row + 1'b1;
                ev_wr_data = wdata[15:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ev_we) begin
            r_mem_even[ev_wr_row] <= ev_wr_data;
        end
        if (r_state == EX_ADDR) begin
            r_even_q <= r_mem_even[ev_rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (od_we) begin
            r_mem_odd[od_wr_row] <= od_wr_data;
        end
        if (r_state == EX_ADDR) begin
            r_odd_q <= r_mem_odd[rd_row];
        end
    end

endmodule

`default_nettype wire

[rtl/mas_result_q.sv]
`timescale 1ns / 1ps
`default_nettype none

module mas_result_q
    import mas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_result     i_res,
    output logic [1:0]       o_level,
    output logic             o_empty,
    input  wire logic        i_pop,
    output t_result          o_res
);

    t_result    r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_level;
    logic       pop_ok;

    assign o_level = r_level;
    assign o_empty = (r_level == 2'd0);
    assign pop_ok  = i_pop && !o_empty;
    assign o_res   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, pop_ok})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/x86_move_and_string_unit.sv]
// An accepted instruction passes the address phase, then the data phase, and is then written
// into the result queue. Address phase: registered memory read; data phase: register and
// memory write. A new instruction can start in the data phase if the result queue has room.
// Reset: synchronous, active low; clears registers, then clears memory one row per cycle,
// holding full high until done.
`timescale 1ns / 1ps
`default_nettype none

module x86_move_and_string_unit
    import mas_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [3:0]        i_mode,
    input  wire logic [3:0]        i_dst_reg,
    input  wire logic [3:0]        i_src_reg,
    input  wire logic              i_byte_access,
    input  wire logic [15:0]       i_imm_value,
    input  wire logic [PA_W-1:0]   i_mem_addr,
    output logic                   empty,
    input  wire logic              pop,
    output logic [15:0]            o_dest_value,
    output logic                   o_mem_written,
    output logic [PA_W-1:0]        o_write_addr,
    output logic [15:0]            o_write_data,
    output logic                   o_write_is_word,
    output logic [15:0]            o_si_now,
    output logic [15:0]            o_di_now
);

    logic       clearing;
    logic       op_valid;
    t_op        op;
    logic       op_pop;
    logic [1:0] rq_level;
    logic       res_push;
    t_result    res_in;
    t_result    res_out;

    mas_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hold        (clearing),
        .i_push        (push),
        .o_full        (full),
        .i_mode        (i_mode),
        .i_dst_reg     (i_dst_reg),
        .i_src_reg     (i_src_reg),
        .i_byte_access (i_byte_access),
        .i_imm_value   (i_imm_value),
        .i_mem_addr    (i_mem_addr),
        .o_op_valid    (op_valid),
        .o_op          (op),
        .i_op_pop      (op_pop)
    );

    mas_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_op_pop   (op_pop),
        .i_rq_level (rq_level),
        .o_res_push (res_push),
        .o_res      (res_in),
        .o_clearing (clearing)
    );

    mas_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_level (rq_level),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res_out)
    );

    assign o_dest_value    = res_out.dest_value;
    assign o_mem_written   = res_out.mem_written;
    assign o_write_addr    = res_out.write_addr;
    assign o_write_data    = res_out.write_data;
    assign o_write_is_word = res_out.write_is_word;
    assign o_si_now        = res_out.si_now;
    assign o_di_now        = res_out.di_now;

endmodule

`default_nettype wire

[rtl/mas_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module mas_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        full,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [15:0] o_dest_value,
    input  wire logic        o_mem_written,
    input  wire logic [19:0] o_write_addr,
    input  wire logic [15:0] o_write_data,
    input  wire logic        o_write_is_word,
    input  wire logic [15:0] o_si_now
);

    a_reset_release: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (full && empty))
        else $error("queue not blocked and empty when reset releases");

    a_no_write_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_mem_written) |->
            (o_write_addr == 20'd0 && o_write_data == 16'd0 && !o_write_is_word))
        else $error("write fields set on a transaction without a memory write");

    a_write_no_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_mem_written) |-> (o_dest_value == 16'd0))
        else $error("memory write transaction reports a destination value");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_dest_value) && $stable(o_si_now)))
        else $error("stalled result transaction changed");

endmodule

bind x86_move_and_string_unit mas_checker u_mas_checker (.*);

`default_nettype wire
